[design/quaternion_rk4_attitude_integrator_top_macros.svh]
// Assertion macros shared by the integrator checker.
// No dependencies.
`ifndef QUATERNION_RK4_ATTITUDE_INTEGRATOR_TOP_MACROS_SVH
`define QUATERNION_RK4_ATTITUDE_INTEGRATOR_TOP_MACROS_SVH
// implication checked on every clock, off during reset
`define QRK_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("%m: check failed");
// next-cycle implication
`define QRK_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("%m: check failed");
`endif

[design/qrk_pkg.sv]
// Package for the quaternion RK4 attitude integrator: constants, types, saturation helpers.
// No dependencies.
`default_nettype none
package qrk_pkg;
    localparam int unsigned QUAT_FRAC_BITS_DEF = 30;
    localparam int unsigned RATE_FRAC_BITS_DEF = 16;
    localparam int unsigned CMD_DEPTH_DEF      = 2;
    localparam logic [31:0] KH_HALF_DEG_TO_RAD = 32'd37480660;
    localparam logic [31:0] KS_ONE_SIXTH       = 32'd357913941;
    localparam logic [31:0] TIME_STEP_RESET    = 32'd21474836;

    localparam logic [2:0] REG_TIME_STEP = 3'd0;
    localparam logic [2:0] REG_INIT_Q0   = 3'd1;
    localparam logic [2:0] REG_INIT_Q1   = 3'd2;
    localparam logic [2:0] REG_INIT_Q2   = 3'd3;
    localparam logic [2:0] REG_INIT_Q3   = 3'd4;

    localparam logic KIND_INTEGRATE = 1'b0;
    localparam logic KIND_RELOAD    = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } t_cmd;

    typedef struct packed {
        logic signed [31:0] q0;
        logic signed [31:0] q1;
        logic signed [31:0] q2;
        logic signed [31:0] q3;
        logic               saturated;
    } t_res;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic clip32(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction
endpackage
`default_nettype wire

[design/qrk_cmd_fifo.sv]
// Small command queue between the front end and the RK4 engine.
// Depends on qrk_pkg.
`default_nettype none
module qrk_cmd_fifo
    import qrk_pkg::*;
#(
    parameter int unsigned DEPTH = CMD_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_cmd      i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_cmd                r_mem [DEPTH];
    logic [AW-1:0]       r_wp, r_rp;
    logic [AW:0]         r_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule
`default_nettype wire

[design/qrk_engine.sv]
// RK4 engine: one shared 35x33 multiplier sequenced over all products.
// Depends on qrk_pkg.
`default_nettype none
module qrk_engine
    import qrk_pkg::*;
#(
    parameter int unsigned QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    parameter int unsigned RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  wire logic [31:0] i_time_step,
    input  wire logic [31:0] i_init [4],
    output logic             o_res_valid,
    output t_res             o_res,
    input  wire logic        i_res_pop
);
    typedef enum logic [3:0] {
        S_IDLE, S_HW, S_HT, S_HWR, S_HTR, S_KMUL, S_KSUM, S_PNT,
        S_SMUL, S_UPD, S_OUT
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic signed [31:0]  r_att [4];
    logic signed [31:0]  r_p [4];
    logic signed [31:0]  r_h [3];
    logic signed [31:0]  r_k [4];
    logic signed [34:0]  r_s [4];
    logic signed [35:0]  r_acc [4];
    logic [1:0]          r_hi;
    logic [1:0]          r_stage;
    logic [1:0]          r_ci;
    logic [1:0]          r_ti;
    logic [63:0]         r_w;
    logic [63:0]         r_a;
    logic signed [65:0]  r_prod;
    logic                r_sat;
    logic                r_res_valid;
    t_res                r_res;

    logic signed [34:0]  m_a;
    logic signed [32:0]  m_b;
    logic signed [65:0]  m_p;
    logic [31:0]         rate_mag;
    logic signed [31:0]  rate_sel;
    logic signed [31:0]  pa;
    logic signed [31:0]  hb;
    logic                neg_term;
    logic signed [33:0]  term;
    logic signed [35:0]  ksum;
    logic signed [33:0]  pnt;
    logic signed [63:0]  inc;
    logic signed [33:0]  upd;

    always_comb begin
        case (r_hi)
            2'd0:    rate_sel = r_cmd.rate_x;
            2'd1:    rate_sel = r_cmd.rate_y;
            default: rate_sel = r_cmd.rate_z;
        endcase
        rate_mag = rate_sel[31] ? 32'(-rate_sel) : rate_sel;
    end

    // product term table: component r_ci, term r_ti
    always_comb begin
        pa = r_p[0];
        hb = r_h[0];
        neg_term = 1'b0;
        case ({r_ci, r_ti})
            4'h0: begin pa = r_p[1]; hb = r_h[0]; neg_term = 1'b1; end
            4'h1: begin pa = r_p[2]; hb = r_h[1]; neg_term = 1'b1; end
            4'h2: begin pa = r_p[3]; hb = r_h[2]; neg_term = 1'b1; end
            4'h4: begin pa = r_p[0]; hb = r_h[0]; end
            4'h5: begin pa = r_p[2]; hb = r_h[2]; end
            4'h6: begin pa = r_p[3]; hb = r_h[1]; neg_term = 1'b1; end
            4'h8: begin pa = r_p[0]; hb = r_h[1]; end
            4'h9: begin pa = r_p[1]; hb = r_h[2]; neg_term = 1'b1; end
            4'hA: begin pa = r_p[3]; hb = r_h[0]; end
            4'hC: begin pa = r_p[0]; hb = r_h[2]; end
            4'hD: begin pa = r_p[1]; hb = r_h[1]; end
            4'hE: begin pa = r_p[2]; hb = r_h[0]; neg_term = 1'b1; end
            default: begin pa = r_p[0]; hb = r_h[0]; end
        endcase
    end

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_HW: begin
                m_a = 35'({1'b0, rate_mag});
                m_b = {1'b0, KH_HALF_DEG_TO_RAD};
            end
            S_HT: begin
                m_a = 35'({1'b0, r_w[31:0]});
                m_b = {1'b0, i_time_step};
            end
            S_HTR: begin
                m_a = 35'({1'b0, r_w[63:32]});
                m_b = {1'b0, i_time_step};
            end
            S_KMUL: begin
                m_a = 35'(pa);
                m_b = 33'(hb);
            end
            S_SMUL: begin
                m_a = r_s[r_ci];
                m_b = {1'b0, KS_ONE_SIXTH};
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_p = 66'(m_a) * 66'(m_b);
    end

    always_comb begin
        term = 34'(r_prod >>> 32);
        if (neg_term) begin
            term = -term;
        end
        ksum = r_acc[r_ci] + 36'(term);
        pnt  = 34'(r_att[r_ci]) + ((r_stage == 2'd2) ? 34'(r_k[r_ci])
                                                       : 34'(r_k[r_ci] >>> 1));
        inc  = 64'(r_prod >>> 31);
        upd  = 34'(r_att[r_ci]) + 34'(inc);
    end

    assign o_cmd_pop   = (r_state == S_IDLE) && i_cmd_valid && !r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_att[0]    <= 32'(64'd1 << QUAT_FRAC_BITS);
            r_att[1]    <= '0;
            r_att[2]    <= '0;
            r_att[3]    <= '0;
            r_hi    <= '0;
            r_stage <= '0;
            r_ci    <= '0;
            r_ti    <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (i_res_pop && r_res_valid) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd <= i_cmd;
                        r_sat <= 1'b0;
                        r_hi  <= '0;
                        if (i_cmd.kind == KIND_RELOAD) begin
                            for (int i = 0; i < 4; i++) begin
                                r_att[i] <= i_init[i];
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_HW;
                        end
                    end
                end
                S_HW: begin
                    r_prod  <= m_p;
                    r_state <= S_HWR;
                end
                S_HWR: begin
                    r_w     <= 64'(r_prod >> RATE_FRAC_BITS);
                    r_state <= S_HT;
                end
                S_HT: begin
                    r_a     <= 64'(m_p >> 32);
                    r_state <= S_HTR;
                end
                S_HTR: begin
                    if ((r_a + m_p[63:0]) > 64'h7FFFFFFF) begin
                        r_sat <= 1'b1;
                        r_h[r_hi] <= rate_sel[31] ? -32'sh7FFFFFFF : 32'sh7FFFFFFF;
                    end else begin
                        r_h[r_hi] <= rate_sel[31] ? 32'(-(r_a + m_p[63:0]))
                                                  : 32'(r_a + m_p[63:0]);
                    end
                    if (r_hi == 2'd2) begin
                        for (int i = 0; i < 4; i++) begin
                            r_p[i]   <= r_att[i];
                            r_acc[i] <= '0;
                            r_s[i]   <= '0;
                        end
                        r_stage <= '0;
                        r_ci    <= '0;
                        r_ti    <= '0;
                        r_state <= S_KMUL;
                    end else begin
                        r_hi    <= r_hi + 1'b1;
                        r_state <= S_HW;
                    end
                end
                S_KMUL: begin
                    r_prod  <= m_p;
                    r_state <= S_KSUM;
                end
                S_KSUM: begin
                    if (r_ti == 2'd2) begin
                        r_k[r_ci] <= sat32(64'(ksum));
                        if (clip32(64'(ksum))) begin
                            r_sat <= 1'b1;
                        end
                        r_s[r_ci] <= r_s[r_ci] + ((r_stage == 2'd1 || r_stage == 2'd2)
                            ? 35'(sat32(64'(ksum))) <<< 1 : 35'(sat32(64'(ksum))));
                        r_acc[r_ci] <= '0;
                        r_ti <= '0;
                        r_ci <= r_ci + 1'b1;
                        if (r_ci == 2'd3) begin
                            r_state <= (r_stage == 2'd3) ? S_SMUL : S_PNT;
                        end else begin
                            r_state <= S_KMUL;
                        end
                    end else begin
                        r_acc[r_ci] <= ksum;
                        r_ti    <= r_ti + 1'b1;
                        r_state <= S_KMUL;
                    end
                end
                S_PNT: begin
                    r_p[r_ci] <= sat32(64'(pnt));
                    if (clip32(64'(pnt))) begin
                        r_sat <= 1'b1;
                    end
                    r_ci <= r_ci + 1'b1;
                    if (r_ci == 2'd3) begin
                        r_stage <= r_stage + 1'b1;
                        r_state <= S_KMUL;
                    end
                end
                S_SMUL: begin
                    r_prod  <= m_p;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_att[r_ci] <= sat32(64'(upd));
                    if (clip32(64'(upd))) begin
                        r_sat <= 1'b1;
                    end
                    r_ci    <= r_ci + 1'b1;
                    r_state <= (r_ci == 2'd3) ? S_OUT : S_SMUL;
                end
                S_OUT: begin
                    r_res.q0        <= r_att[0];
                    r_res.q1        <= r_att[1];
                    r_res.q2        <= r_att[2];
                    r_res.q3        <= r_att[3];
                    r_res.saturated <= r_sat;
                    r_res_valid     <= 1'b1;
                    r_state         <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/quaternion_rk4_attitude_integrator_top.sv]
// Top level of the quaternion RK4 attitude integrator.
// Depends on qrk_pkg, qrk_cmd_fifo, qrk_engine.
//
// Usage: push a beat on push while full is low. kind 0 integrates one
// gyro sample (rates in deg/s, Q15.16), kind 1 reloads the attitude from
// the init registers. Each beat yields one result beat: the attitude after
// it and a saturation flag, shown while empty is low, taken by pop.
// From an idle engine a reload takes the command and then shows the result;
// an integrate takes the command, forms the three half-angle terms, runs 4
// stages x 12 products on the one shared multiplier, then the stage points,
// the four updates and the output step.
// The engine finishes one integrate before it takes the next command, as
// all its products share the one multiplier in the engine.
// A two-entry command queue takes beats while the engine works and while
// a result waits; the engine holds until the result is popped.
// Reset clears the queue and the result, loads the register defaults and
// sets the attitude to the default initial quaternion (1,0,0,0).
// Configuration writes take effect at once; write only when idle.
`default_nettype none
module quaternion_rk4_attitude_integrator_top
    import qrk_pkg::*;
#(
    parameter int unsigned QUAT_FRAC_BITS = QUAT_FRAC_BITS_DEF,
    parameter int unsigned RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic               i_kind,
    input  wire logic signed [31:0] i_rate_x,
    input  wire logic signed [31:0] i_rate_y,
    input  wire logic signed [31:0] i_rate_z,
    output logic                    empty,
    input  wire logic               pop,
    output logic signed [31:0]      o_att_q0,
    output logic signed [31:0]      o_att_q1,
    output logic signed [31:0]      o_att_q2,
    output logic signed [31:0]      o_att_q3,
    output logic                    o_saturated,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    logic [31:0] r_time_step;
    logic [31:0] r_init [4];
    t_cmd        cmd_in, cmd_out;
    logic        cmd_valid, cmd_pop, res_valid;
    t_res        res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= TIME_STEP_RESET;
            r_init[0]   <= 32'(64'd1 << QUAT_FRAC_BITS);
            r_init[1]   <= '0;
            r_init[2]   <= '0;
            r_init[3]   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TIME_STEP: r_time_step <= i_cfg_data;
                REG_INIT_Q0:   r_init[0]   <= i_cfg_data;
                REG_INIT_Q1:   r_init[1]   <= i_cfg_data;
                REG_INIT_Q2:   r_init[2]   <= i_cfg_data;
                REG_INIT_Q3:   r_init[3]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cmd_in = '{kind: i_kind, rate_x: i_rate_x, rate_y: i_rate_y, rate_z: i_rate_z};

    qrk_cmd_fifo #(.DEPTH(CMD_DEPTH_DEF)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_data(cmd_in),
        .o_full(full), .i_pop(cmd_pop), .o_valid(cmd_valid), .o_data(cmd_out)
    );

    qrk_engine #(
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS), .RATE_FRAC_BITS(RATE_FRAC_BITS)
    ) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .i_cmd(cmd_out), .o_cmd_pop(cmd_pop), .i_time_step(r_time_step),
        .i_init(r_init), .o_res_valid(res_valid), .o_res(res),
        .i_res_pop(pop)
    );

    assign empty       = !res_valid;
    assign o_att_q0    = res.q0;
    assign o_att_q1    = res.q1;
    assign o_att_q2    = res.q2;
    assign o_att_q3    = res.q3;
    assign o_saturated = res.saturated;
endmodule
`default_nettype wire

[design/qrk_checker.sv]
// Port-level checker for the integrator, bound to the top level.
// Depends on quaternion_rk4_attitude_integrator_top_macros.svh.
`default_nettype none
`include "quaternion_rk4_attitude_integrator_top_macros.svh"
module qrk_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        push,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [31:0] o_att_q0,
    input wire logic        o_saturated
);
    `QRK_ASSERT_NXT(a_result_holds, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_att_q0))
    `QRK_ASSERT_NXT(a_pop_drains, i_clk, i_rst_n, !empty && pop, empty)
    `QRK_ASSERT_NXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, empty && !full)
    `QRK_ASSERT_IMP(a_sat_known, i_clk, i_rst_n, !empty, !$isunknown(o_saturated))
endmodule

bind quaternion_rk4_attitude_integrator_top qrk_checker u_qrk_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full), .empty(empty),
    .pop(pop), .o_att_q0(o_att_q0), .o_saturated(o_saturated)
);
`default_nettype wire
